// ----- design/hss_pkg.sv -----
`timescale 1ns / 1ps

package hss_pkg;

  // Field widths fixed by the item and result formats
  localparam int CODE_W = 3;
  localparam int POS_W  = 3;
  localparam int TIME_W = 32;
  localparam int CAND_W = 4;
  localparam int CNT_W  = 8;
  localparam int SEQ_W  = 32;
  localparam int PER_W  = 16;

  localparam int DEF_MOTOR_COUNT = 2;
  localparam int QUEUE_DEPTH     = 2;

  // Six-step sequence length and the marker for codes outside it
  localparam logic [POS_W-1:0]  SEQ_LAST     = 3'd5;
  localparam logic [POS_W-1:0]  NO_POS       = 3'd7;
  localparam logic [CAND_W-1:0] NO_CANDIDATE = 4'd8;
  localparam logic [CNT_W-1:0]  CNT_MAX      = 8'hFF;

  // Item operations
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_EDGE   = 1'b1;

  // Register map, word index on the configuration port
  localparam int             ADDR_W             = 4;
  localparam logic [1:0]     REG_SAMPLE_PERIOD  = 2'd0;
  localparam logic [1:0]     REG_STABLE_COUNT   = 2'd1;
  localparam logic [1:0]     REG_MIN_TRANSITION = 2'd2;

  localparam logic [PER_W-1:0] RST_SAMPLE_PERIOD  = 16'd0;
  localparam logic [CNT_W-1:0] RST_STABLE_COUNT   = 8'd1;
  localparam logic [PER_W-1:0] RST_MIN_TRANSITION = 16'd0;

  typedef struct packed {
    logic [PER_W-1:0] sample_period;
    logic [CNT_W-1:0] stable_count;
    logic [PER_W-1:0] min_transition;
  } cfg_t;

  // Classified item as it travels from front to back
  typedef struct packed {
    logic              op;
    logic              motor;
    logic [CODE_W-1:0] uvw_code;
    logic [TIME_W-1:0] now_ms;
    logic              code_ok;
    logic [POS_W-1:0]  pos;
  } item_t;

  // Position of a UVW code in the sequence 1,5,4,6,2,3
  function automatic logic [POS_W-1:0] pos_of_code(input logic [CODE_W-1:0] code);
    logic [POS_W-1:0] p;
    case (code)
      3'd1:    p = 3'd0;
      3'd5:    p = 3'd1;
      3'd4:    p = 3'd2;
      3'd6:    p = 3'd3;
      3'd2:    p = 3'd4;
      3'd3:    p = 3'd5;
      default: p = NO_POS;
    endcase
    return p;
  endfunction

  function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
    return (p == SEQ_LAST) ? '0 : p + 3'd1;
  endfunction

  // Two codes are neighbors when one follows the other around the sequence
  function automatic logic codes_adjacent(input logic [CODE_W-1:0] a,
                                          input logic [CODE_W-1:0] b);
    logic [POS_W-1:0] pa;
    logic [POS_W-1:0] pb;
    pa = pos_of_code(a);
    pb = pos_of_code(b);
    if (pa == NO_POS || pb == NO_POS) begin
      return 1'b0;
    end
    return (next_pos(pa) == pb) || (next_pos(pb) == pa);
  endfunction

endpackage

// ----- design/hss_ifs.sv -----
`timescale 1ns / 1ps

// Input channel: one hall sample or edge event per transaction
interface hss_item_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic        motor;
  logic [2:0]  uvw_code;
  logic [31:0] now_ms;

  modport source (output valid, op, motor, uvw_code, now_ms, input ready);
  modport sink   (input valid, op, motor, uvw_code, now_ms, output ready);
endinterface

// Output channel: one accepted hall transition per transaction
interface hss_result_if;
  logic        valid;
  logic        ready;
  logic        out_motor;
  logic [2:0]  accepted_code;
  logic [2:0]  sector;
  logic [31:0] accept_time_ms;
  logic [31:0] sequence_number;

  modport source (output valid, out_motor, accepted_code, sector, accept_time_ms,
                  sequence_number, input ready);
  modport sink   (input valid, out_motor, accepted_code, sector, accept_time_ms,
                  sequence_number, output ready);
endinterface

// ----- design/hss_cfg.sv -----
`timescale 1ns / 1ps

module hss_cfg
  import hss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Write the addressed register in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_period  <= RST_SAMPLE_PERIOD;
      cfg.stable_count   <= RST_STABLE_COUNT;
      cfg.min_transition <= RST_MIN_TRANSITION;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SAMPLE_PERIOD:  cfg.sample_period  <= pwdata[PER_W-1:0];
        REG_STABLE_COUNT:   cfg.stable_count   <= pwdata[CNT_W-1:0];
        REG_MIN_TRANSITION: cfg.min_transition <= pwdata[PER_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register, zero beyond the map
  always_comb begin
    case (reg_idx)
      REG_SAMPLE_PERIOD:  prdata = 32'(cfg.sample_period);
      REG_STABLE_COUNT:   prdata = 32'(cfg.stable_count);
      REG_MIN_TRANSITION: prdata = 32'(cfg.min_transition);
      default:            prdata = '0;
    endcase
  end

endmodule

// ----- design/hss_front.sv -----
`timescale 1ns / 1ps

module hss_front
  import hss_pkg::*;
#(
  parameter int MOTOR_COUNT = DEF_MOTOR_COUNT
) (
  hss_item_if.sink item,
  input  logic     queue_ready,
  output logic     push_valid,
  output item_t    push_item
);

  logic motor_ok;

  // Drop items for motors that do not exist; accept them all the same
  assign motor_ok   = 32'(item.motor) < MOTOR_COUNT;
  assign item.ready = queue_ready;
  assign push_valid = item.valid && motor_ok;

  // Classify the code before it is queued
  always_comb begin
    push_item.op       = item.op;
    push_item.motor    = item.motor;
    push_item.uvw_code = item.uvw_code;
    push_item.now_ms   = item.now_ms;
    push_item.pos      = pos_of_code(item.uvw_code);
    push_item.code_ok  = push_item.pos != NO_POS;
  end

endmodule

// ----- design/hss_queue.sv -----
`timescale 1ns / 1ps

module hss_queue
  import hss_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  input  item_t push_item,
  output logic  push_ready,
  output logic  pop_valid,
  output item_t pop_item,
  input  logic  pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  item_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = fill != CNT_QW'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- design/hss_back.sv -----
`timescale 1ns / 1ps

module hss_back
  import hss_pkg::*;
#(
  parameter int MOTOR_COUNT = DEF_MOTOR_COUNT
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  pop_valid,
  input  item_t pop_item,
  output logic  pop,
  hss_result_if.source result
);

  localparam int MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  typedef struct packed {
    logic [CODE_W-1:0] latest_code;
    logic              has_latest;
    logic [CAND_W-1:0] cand_code;
    logic [CNT_W-1:0]  cand_count;
    logic [TIME_W-1:0] last_sample;
    logic [TIME_W-1:0] last_accept;
    logic [SEQ_W-1:0]  trans_count;
  } motor_state_t;

  motor_state_t      mstate [MOTOR_COUNT];
  motor_state_t      cur;
  motor_state_t      state_next;
  logic [MIDX_W-1:0] midx;
  logic [TIME_W-1:0] elapsed_sample;
  logic [TIME_W-1:0] elapsed_accept;
  logic              rate_drop;
  logic              same_cand;
  logic [CNT_W-1:0]  cnt_inc;
  logic              offer;
  logic              reject;
  logic              accept;
  logic              out_valid;

  assign midx = MIDX_W'(pop_item.motor);
  assign cur  = mstate[midx];
  assign pop  = pop_valid && (!out_valid || result.ready);

  // Evaluate rate limit, debounce and acceptance for the head item
  always_comb begin
    elapsed_sample = pop_item.now_ms - cur.last_sample;
    elapsed_accept = pop_item.now_ms - cur.last_accept;
    rate_drop = (cfg.sample_period != '0) &&
                (elapsed_sample < TIME_W'(cfg.sample_period));
    same_cand = {1'b0, pop_item.uvw_code} == cur.cand_code;
    cnt_inc   = (cur.cand_count == CNT_MAX) ? CNT_MAX : cur.cand_count + 8'd1;
    offer     = (pop_item.op == OP_EDGE) ||
                (!rate_drop && same_cand && (cnt_inc >= cfg.stable_count));
    reject    = cur.has_latest &&
                ((pop_item.uvw_code == cur.latest_code) ||
                 (elapsed_accept < TIME_W'(cfg.min_transition)) ||
                 !codes_adjacent(cur.latest_code, pop_item.uvw_code));
    accept    = offer && pop_item.code_ok && !reject;

    state_next = cur;
    if (pop_item.op == OP_SAMPLE && !rate_drop) begin
      state_next.last_sample = pop_item.now_ms;
      if (same_cand) begin
        state_next.cand_count = cnt_inc;
      end else begin
        state_next.cand_code  = {1'b0, pop_item.uvw_code};
        state_next.cand_count = 8'd1;
      end
    end
    if (offer && !pop_item.code_ok) begin
      state_next.cand_code  = NO_CANDIDATE;
      state_next.cand_count = '0;
    end
    if (accept) begin
      state_next.cand_code   = {1'b0, pop_item.uvw_code};
      state_next.cand_count  = cfg.stable_count;
      state_next.trans_count = cur.trans_count + 32'd1;
      state_next.latest_code = pop_item.uvw_code;
      state_next.has_latest  = 1'b1;
      state_next.last_accept = pop_item.now_ms;
    end
  end

  // Update motor state and the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        mstate[i] <= '{latest_code: '0, has_latest: 1'b0, cand_code: NO_CANDIDATE,
                       cand_count: '0, last_sample: '0, last_accept: '0,
                       trans_count: '0};
      end
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        mstate[midx] <= state_next;
        out_valid    <= accept;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the result payload on an accepted transition
  always_ff @(posedge clk) begin
    if (pop && accept) begin
      result.out_motor       <= pop_item.motor;
      result.accepted_code   <= pop_item.uvw_code;
      result.sector          <= pop_item.pos + 3'd1;
      result.accept_time_ms  <= pop_item.now_ms;
      result.sequence_number <= state_next.trans_count;
    end
  end

  assign result.valid = out_valid;

endmodule

// ----- design/hall_sensor_state_filter.sv -----
`timescale 1ns / 1ps

// Hall sensor state filter for up to MOTOR_COUNT motors.
// item channel: one transaction per hall sample (op 0) or edge event (op 1),
//   with motor, UVW uvw_code and now_ms. Samples are rate limited by
//   sample_period_ms and debounced by stable_count; edge events go straight
//   to acceptance. Items for a motor that does not exist are taken and dropped.
// result channel: one transaction per accepted hall transition, carrying the
//   motor, code, sector 1..6, the item's time and the motor's running count.
// Configuration: APB registers at 0x0 (sample_period_ms), 0x4 (stable_count)
//   and 0x8 (min_transition_ms); write them only while the block is idle.
// Throughput: one item per cycle while the receiver keeps up. An item is
//   registered in the queue and then in the back end's result register,
//   and its result is valid once it has passed both.
//   The per-motor state is read, updated and written back on each pop.
// A two-entry queue sits between the classifying front end and the back end,
//   and the result register lets the next item proceed while the output is
//   taken in the same cycle. When the receiver stalls, the result holds, the
//   queue fills, and item.ready falls once it is full.
// Reset clears all motor state, the queue and the output, and restores the
//   register defaults; the block is ready for items as soon as reset is released.
module hall_sensor_state_filter
  import hss_pkg::*;
#(
  parameter int MOTOR_COUNT = DEF_MOTOR_COUNT
) (
  input  logic              clk,
  input  logic              rst,
  hss_item_if.sink          item,
  hss_result_if.source      result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t  cfg;
  logic  queue_ready;
  logic  push_valid;
  item_t push_item;
  logic  pop_valid;
  item_t pop_item;
  logic  pop;

  assign pready = 1'b1;

  hss_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  hss_front #(.MOTOR_COUNT(MOTOR_COUNT)) u_front (
    .item        (item),
    .queue_ready (queue_ready),
    .push_valid  (push_valid),
    .push_item   (push_item)
  );

  hss_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (queue_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop        (pop)
  );

  hss_back #(.MOTOR_COUNT(MOTOR_COUNT)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop       (pop),
    .result    (result)
  );

endmodule

// ----- design/hss_checker.sv -----
`timescale 1ns / 1ps

module hss_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input logic [2:0]  accepted_code,
  input logic [2:0]  sector,
  input logic [31:0] sequence_number
);

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(accepted_code) &&
                                      $stable(sequence_number))
    else $error("stalled result changed");

  // Emit only valid hall codes with a sector in range
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> accepted_code != 3'd0 && accepted_code != 3'd7 &&
                     sector != 3'd0 && sector != 3'd7)
    else $error("result code or sector out of range");

  // No result straight out of reset
  assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  // Keep the code to sector mapping fixed
  assert property (@(posedge clk) disable iff (rst)
    result_valid && accepted_code == 3'd1 |-> sector == 3'd1)
    else $error("code 1 not mapped to sector 1");

endmodule

bind hall_sensor_state_filter hss_checker u_hss_checker (
  .clk             (clk),
  .rst             (rst),
  .result_valid    (result.valid),
  .result_ready    (result.ready),
  .accepted_code   (result.accepted_code),
  .sector          (result.sector),
  .sequence_number (result.sequence_number)
);

// ----- tb/hall_sensor_state_filter_test.sv -----
`timescale 1ns / 1ps

module hall_sensor_state_filter_test;
  import hss_pkg::*;

  localparam int MOTORS        = DEF_MOTOR_COUNT;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_STALL    = 300;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int MAX_GAP       = 16;

  typedef struct packed {
    logic              op;
    logic              motor;
    logic [CODE_W-1:0] uvw_code;
    logic [TIME_W-1:0] now_ms;
  } hall_item_t;

  typedef struct packed {
    logic              motor;
    logic [CODE_W-1:0] code;
    logic [POS_W-1:0]  sector;
    logic [TIME_W-1:0] time_ms;
    logic [SEQ_W-1:0]  seq_num;
  } hall_transition_t;

  typedef enum logic [1:0] {ROW_PREDICTED, ROW_TYPED, ROW_REG_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    hall_item_t       stim;
    logic             typed_hit;
    hall_transition_t typed_out;
    logic [1:0]       reg_idx;
    logic [31:0]      reg_val;
  } directed_row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  hss_item_if   item_ch ();
  hss_result_if result_ch ();

  hall_sensor_state_filter #(.MOTOR_COUNT(MOTORS)) DUT (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the filter state and registers
  cfg_t              cfg_shadow;
  logic [CODE_W-1:0] held_code  [MOTORS];
  logic              held_valid [MOTORS];
  logic [CAND_W-1:0] cand_code  [MOTORS];
  logic [CNT_W-1:0]  cand_cnt   [MOTORS];
  logic [TIME_W-1:0] sample_at  [MOTORS];
  logic [TIME_W-1:0] accept_at  [MOTORS];
  logic [SEQ_W-1:0]  accept_cnt [MOTORS];

  hall_transition_t  pending_transitions [$];
  directed_row_t     directed_rows [$];

  int                send_idle_pct;
  int                recv_idle_pct;
  bit                stall_toggle;
  int                items_sent;
  int                transitions_checked;
  int                mismatch_count;
  int                reg_writes;
  int                walk_pos  [MOTORS];
  logic [TIME_W-1:0] walk_time [MOTORS];

  always #5 clk = ~clk;

  // Sector 1..6 of a UVW code along 1,5,4,6,2,3; zero for the invalid codes
  function automatic logic [POS_W-1:0] sector_of(input logic [CODE_W-1:0] code);
    case (code)
      3'd1:    return 3'd1;
      3'd5:    return 3'd2;
      3'd4:    return 3'd3;
      3'd6:    return 3'd4;
      3'd2:    return 3'd5;
      3'd3:    return 3'd6;
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic [CODE_W-1:0] code_at(input int pos);
    case (pos)
      0:       return 3'd1;
      1:       return 3'd5;
      2:       return 3'd4;
      3:       return 3'd6;
      4:       return 3'd2;
      default: return 3'd3;
    endcase
  endfunction

  function automatic bit sectors_touch(input logic [POS_W-1:0] a, input logic [POS_W-1:0] b);
    logic [POS_W-1:0] a_next;
    logic [POS_W-1:0] b_next;
    a_next = (a == 3'd6) ? 3'd1 : a + 3'd1;
    b_next = (b == 3'd6) ? 3'd1 : b + 3'd1;
    return (a_next == b) || (b_next == a);
  endfunction

  function automatic void clear_shadow();
    for (int m = 0; m < MOTORS; m++) begin
      held_code[m]  = '0;
      held_valid[m] = 1'b0;
      cand_code[m]  = NO_CANDIDATE;
      cand_cnt[m]   = '0;
      sample_at[m]  = '0;
      accept_at[m]  = '0;
      accept_cnt[m] = '0;
    end
    cfg_shadow.sample_period  = RST_SAMPLE_PERIOD;
    cfg_shadow.stable_count   = RST_STABLE_COUNT;
    cfg_shadow.min_transition = RST_MIN_TRANSITION;
  endfunction

  // Offer a code for acceptance; drop the candidate on an invalid code and update the motor state when it is taken
  function automatic bit commit_code(input int m, input logic [CODE_W-1:0] code,
                                     input logic [TIME_W-1:0] now,
                                     output hall_transition_t tr);
    logic [POS_W-1:0]  s;
    logic [TIME_W-1:0] since;
    s     = sector_of(code);
    since = now - accept_at[m];
    tr    = '0;
    // invalid code drops the candidate
    if (s == 3'd0) begin
      cand_code[m] = NO_CANDIDATE;
      cand_cnt[m]  = '0;
      return 1'b0;
    end
    // reject a repeat, an early change or a jump across the sequence
    if (held_valid[m]) begin
      if (code == held_code[m] || since < cfg_shadow.min_transition ||
          !sectors_touch(sector_of(held_code[m]), s)) begin
        return 1'b0;
      end
    end
    cand_code[m]  = CAND_W'(code);
    cand_cnt[m]   = cfg_shadow.stable_count;
    accept_cnt[m] = accept_cnt[m] + 1'b1;
    held_code[m]  = code;
    held_valid[m] = 1'b1;
    accept_at[m]  = now;
    tr.motor      = m[0];
    tr.code       = code;
    tr.sector     = s;
    tr.time_ms    = now;
    tr.seq_num    = accept_cnt[m];
    return 1'b1;
  endfunction

  // Predict the transition, if any, that one input transaction causes
  function automatic bit filter_step(input hall_item_t it, output hall_transition_t tr);
    int                m;
    logic [TIME_W-1:0] since;
    m     = it.motor;
    since = it.now_ms - sample_at[m];
    tr    = '0;
    if (m >= MOTORS) begin
      return 1'b0;
    end
    if (it.op == OP_EDGE) begin
      return commit_code(m, it.uvw_code, it.now_ms, tr);
    end
    // rate limit the periodic samples
    if (cfg_shadow.sample_period != '0 && since < cfg_shadow.sample_period) begin
      return 1'b0;
    end
    sample_at[m] = it.now_ms;
    // debounce: a new code restarts the count, an equal one raises it
    if (CAND_W'(it.uvw_code) != cand_code[m]) begin
      cand_code[m] = CAND_W'(it.uvw_code);
      cand_cnt[m]  = 8'd1;
      return 1'b0;
    end
    if (cand_cnt[m] != CNT_MAX) begin
      cand_cnt[m] = cand_cnt[m] + 1'b1;
    end
    if (cand_cnt[m] < cfg_shadow.stable_count) begin
      return 1'b0;
    end
    return commit_code(m, it.uvw_code, it.now_ms, tr);
  endfunction

  function automatic void add_item_row(input logic op, input logic motor,
                                       input logic [2:0] code, input logic [31:0] now);
    directed_row_t row;
    row      = '0;
    row.kind = ROW_PREDICTED;
    row.stim = {op, motor, code, now};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_typed_row(input logic op, input logic motor,
                                        input logic [2:0] code, input logic [31:0] now,
                                        input logic hit, input logic out_motor,
                                        input logic [2:0] out_code, input logic [2:0] out_sector,
                                        input logic [31:0] out_seq);
    directed_row_t row;
    row           = '0;
    row.kind      = ROW_TYPED;
    row.stim      = {op, motor, code, now};
    row.typed_hit = hit;
    row.typed_out = {out_motor, out_code, out_sector, now, out_seq};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_reg_row(input logic [1:0] idx, input logic [31:0] value);
    directed_row_t row;
    row         = '0;
    row.kind    = ROW_REG_WRITE;
    row.reg_idx = idx;
    row.reg_val = value;
    directed_rows.push_back(row);
  endfunction

  // APB write: setup then access, register taken at the access edge
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SAMPLE_PERIOD:  cfg_shadow.sample_period  = value[PER_W-1:0];
      REG_STABLE_COUNT:   cfg_shadow.stable_count   = value[CNT_W-1:0];
      REG_MIN_TRANSITION: cfg_shadow.min_transition = value[PER_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drop valid, wait for every expected transition, then let the pipe empty
  task automatic settle_block(input int max_cycles);
    int waited;
    waited = 0;
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (pending_transitions.size() != 0 && waited < max_cycles) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one transaction after a random gap and predict at acceptance
  task automatic send_item(input hall_item_t it, input bit typed, input bit typed_hit,
                           input hall_transition_t typed_out);
    hall_transition_t tr;
    bit               hit;
    int               gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) begin
      gap++;
    end
    @(negedge clk);
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid    <= 1'b1;
    item_ch.op       <= it.op;
    item_ch.motor    <= it.motor;
    item_ch.uvw_code <= it.uvw_code;
    item_ch.now_ms   <= it.now_ms;
    do @(posedge clk); while (!item_ch.ready);
    hit = filter_step(it, tr);
    items_sent++;
    if (typed) begin
      if (typed_hit) begin
        pending_transitions.push_back(typed_out);
      end
    end else if (hit) begin
      pending_transitions.push_back(tr);
    end
  endtask

  // One register setting followed by random rotor walks with some noise
  task automatic run_segment(input int count, input logic [31:0] period,
                             input logic [31:0] stable, input logic [31:0] min_t,
                             input int send_pct, input int recv_pct, input int edge_pct,
                             input bit squeeze);
    hall_item_t it;
    int         gap_ms;
    int         m;
    int         dt;
    int         r;
    bit         step;
    settle_block(DRAIN_LIMIT);
    write_reg(REG_SAMPLE_PERIOD, period);
    write_reg(REG_STABLE_COUNT, stable);
    write_reg(REG_MIN_TRANSITION, min_t);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    gap_ms = (period > min_t) ? period : min_t;
    for (int i = 0; i < MOTORS; i++) begin
      walk_time[i] = $urandom;
      walk_pos[i]  = $urandom_range(0, 5);
    end
    for (int n = 0; n < count; n++) begin
      // hold off the receiver while items keep coming, later drain fully
      if (squeeze && n == count / 3) begin
        stall_toggle = !stall_toggle;
      end
      if (squeeze && n == (2 * count) / 3) begin
        settle_block(DRAIN_LIMIT);
      end
      m        = $urandom_range(0, MOTORS - 1);
      it.motor = m[0];
      r        = $urandom_range(0, 99);
      if (r < 12) begin
        // noise: any op, any code, time near the walk or anywhere
        it.op       = 1'($urandom_range(0, 1));
        it.uvw_code = CODE_W'($urandom_range(0, 7));
        it.now_ms   = ($urandom_range(0, 1) == 1) ? $urandom
                                                  : walk_time[m] + $urandom_range(0, 3);
      end else begin
        it.op = ($urandom_range(0, 99) < edge_pct) ? OP_EDGE : OP_SAMPLE;
        r     = $urandom_range(0, 9);
        if (r < 4) begin
          dt = $urandom_range(0, 3);
        end else if (r < 8) begin
          dt = (gap_ms == 0) ? $urandom_range(0, 2) : gap_ms - 1 + $urandom_range(0, 2);
        end else begin
          dt = $urandom_range(0, 2 * gap_ms + 20);
        end
        walk_time[m] = walk_time[m] + dt;
        if (it.op == OP_EDGE) begin
          step = ($urandom_range(0, 1) == 1);
        end else begin
          step = ($urandom_range(0, stable + 1) == 0);
        end
        // advance, back up, or now and then jump across the sequence
        if (step) begin
          r = $urandom_range(0, 19);
          if (r < 9) begin
            walk_pos[m] = (walk_pos[m] + 1) % 6;
          end else if (r < 18) begin
            walk_pos[m] = (walk_pos[m] + 5) % 6;
          end else begin
            walk_pos[m] = (walk_pos[m] + 2 + $urandom_range(0, 1)) % 6;
          end
        end
        it.uvw_code = code_at(walk_pos[m]);
        it.now_ms   = walk_time[m];
      end
      send_item(it, 1'b0, 1'b0, '0);
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s differs, expected %0h, actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Drive the result ready: random stalls plus a long hold-off on request
  initial begin
    int hold_left;
    bit stall_seen;
    hold_left  = 0;
    stall_seen = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_toggle != stall_seen) begin
        stall_seen = stall_toggle;
        hold_left  = LONG_STALL;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Compare each result transaction with the oldest expected transition
  always @(posedge clk) begin
    hall_transition_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_transitions.size() == 0) begin
        $display("%0t: expected no transition, actual motor %0d code %0d seq %0d", $time,
                 result_ch.out_motor, result_ch.accepted_code, result_ch.sequence_number);
        mismatch_count++;
      end else begin
        want = pending_transitions.pop_front();
        check_field("out_motor", 32'(want.motor), 32'(result_ch.out_motor));
        check_field("accepted_code", 32'(want.code), 32'(result_ch.accepted_code));
        check_field("sector", 32'(want.sector), 32'(result_ch.sector));
        check_field("accept_time_ms", want.time_ms, result_ch.accept_time_ms);
        check_field("sequence_number", want.seq_num, result_ch.sequence_number);
        transitions_checked++;
      end
    end
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    item_ch.valid    = 1'b0;
    item_ch.op       = OP_SAMPLE;
    item_ch.motor    = 1'b0;
    item_ch.uvw_code = '0;
    item_ch.now_ms   = '0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    clear_shadow();

    // Directed rows: operations, invalid codes, debounce, limits, wrap
    add_typed_row(OP_EDGE, 1'b0, 3'd1, 32'd0, 1'b1, 1'b0, 3'd1, 3'd1, 32'd1);
    add_typed_row(OP_EDGE, 1'b0, 3'd0, 32'd1, 1'b0, 1'b0, 3'd0, 3'd0, 32'd0);
    add_typed_row(OP_EDGE, 1'b0, 3'd7, 32'd2, 1'b0, 1'b0, 3'd0, 3'd0, 32'd0);
    add_item_row(OP_EDGE, 1'b0, 3'd1, 32'd5);
    add_item_row(OP_EDGE, 1'b0, 3'd5, 32'd10);
    add_item_row(OP_EDGE, 1'b0, 3'd6, 32'd11);
    add_item_row(OP_EDGE, 1'b0, 3'd4, 32'd12);
    add_item_row(OP_SAMPLE, 1'b0, 3'd6, 32'd20);
    add_item_row(OP_SAMPLE, 1'b0, 3'd6, 32'd21);
    add_item_row(OP_SAMPLE, 1'b1, 3'd7, 32'd100);
    add_typed_row(OP_SAMPLE, 1'b1, 3'd7, 32'd101, 1'b0, 1'b0, 3'd0, 3'd0, 32'd0);
    add_item_row(OP_SAMPLE, 1'b1, 3'd3, 32'hFFFF_FFFF);
    add_typed_row(OP_SAMPLE, 1'b1, 3'd3, 32'hFFFF_FFFF, 1'b1, 1'b1, 3'd3, 3'd6, 32'd1);
    add_item_row(OP_EDGE, 1'b1, 3'd1, 32'd0);
    add_item_row(OP_EDGE, 1'b1, 3'd2, 32'd0);
    add_item_row(OP_EDGE, 1'b0, 3'd2, 32'd30);
    add_reg_row(REG_SAMPLE_PERIOD, 32'd100);
    add_reg_row(REG_MIN_TRANSITION, 32'd50);
    add_item_row(OP_SAMPLE, 1'b0, 3'd3, 32'd50);
    add_item_row(OP_SAMPLE, 1'b0, 3'd3, 32'd121);
    add_item_row(OP_SAMPLE, 1'b0, 3'd3, 32'd221);
    add_item_row(OP_EDGE, 1'b0, 3'd1, 32'd230);
    add_item_row(OP_EDGE, 1'b0, 3'd1, 32'd271);
    add_reg_row(REG_STABLE_COUNT, 32'd0);
    add_item_row(OP_SAMPLE, 1'b1, 3'd5, 32'd99);
    add_item_row(OP_SAMPLE, 1'b1, 3'd5, 32'd199);

    // Hold reset, then release at a falling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_REG_WRITE: begin
          settle_block(DRAIN_LIMIT);
          write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
        end
        ROW_TYPED: begin
          send_item(directed_rows[i].stim, 1'b1, directed_rows[i].typed_hit,
                    directed_rows[i].typed_out);
        end
        default: begin
          send_item(directed_rows[i].stim, 1'b0, 1'b0, '0);
        end
      endcase
    end

    // Random part: sender idles lightly, then receiver, then neither
    run_segment(200, 32'd0, 32'd1, 32'd0, 6, 49, 30, 1'b0);
    run_segment(180, 32'd10, 32'd3, 32'd20, 6, 49, 30, 1'b0);
    run_segment(180, $urandom_range(1, 200), $urandom_range(2, 8), $urandom_range(0, 300),
                49, 6, 30, 1'b0);
    run_segment(80, 32'hFFFF, 32'hFF, 32'hFFFF, 49, 6, 70, 1'b0);
    run_segment(200, 32'd0, 32'd0, 32'd0, 0, 0, 30, 1'b0);
    run_segment(210, 32'd1, 32'd2, 32'd1, 0, 0, 30, 1'b1);

    // Drain and report anything still owed
    settle_block(DRAIN_LIMIT);
    if (pending_transitions.size() != 0) begin
      $display("%0t: %0d expected transitions never arrived, oldest motor %0d code %0d",
               $time, pending_transitions.size(), pending_transitions[0].motor,
               pending_transitions[0].code);
      mismatch_count += pending_transitions.size();
    end

    $display("Sent %0d hall items, checked %0d accepted transitions, %0d register writes.",
             items_sent, transitions_checked, reg_writes);
    $display("Covered debounce, rate limit, early and skipped changes, long stall and drain.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/hss_pkg.sv
design/hss_ifs.sv
design/hss_cfg.sv
design/hss_front.sv
design/hss_queue.sv
design/hss_back.sv
design/hall_sensor_state_filter.sv
design/hss_checker.sv
tb/hall_sensor_state_filter_test.sv
